FILE: sv/stes_pkg.sv
// stes_pkg: widths, types and register indexes of the surface texture extent setup
// no dependencies
`timescale 1ns / 1ps

package stes_pkg;

  localparam int unsigned PosW   = 24;  // vertex coordinate, Q16.8
  localparam int unsigned AxisW  = 24;  // axis component Q8.16, offset Q16.8
  localparam int unsigned SizeW  = 13;  // texture size
  localparam int unsigned ProdW  = 48;  // one coordinate times one axis component
  localparam int unsigned AccW   = 50;  // sum of three products
  localparam int unsigned ProjW  = 34;  // projection in Q.8
  localparam int unsigned DvW    = 42;  // magnitude of projection times 256
  localparam int unsigned DvCntW = 6;
  localparam int unsigned CoordW = 33;
  localparam int unsigned OrgW   = 25;
  localparam int unsigned SpanW  = 26;
  localparam int unsigned TriW   = 6;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_S_AXIS_X = 3'd0,
    REG_S_AXIS_Y = 3'd1,
    REG_S_AXIS_Z = 3'd2,
    REG_S_SHIFT  = 3'd3,
    REG_T_AXIS_X = 3'd4,
    REG_T_AXIS_Y = 3'd5,
    REG_T_AXIS_Z = 3'd6,
    REG_T_SHIFT  = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PROJ,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  // control from the sequencer to both dividers
  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

endpackage

FILE: sv/stes_in_if.sv
// stes_in_if: vertex item channel (valid, ready, vertex payload)
// depends on stes_pkg
`timescale 1ns / 1ps

interface stes_in_if
  import stes_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [PosW-1:0]  pos_x;
  logic signed [PosW-1:0]  pos_y;
  logic signed [PosW-1:0]  pos_z;
  logic        [SizeW-1:0] tex_width;
  logic        [SizeW-1:0] tex_height;
  logic                    final_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, tex_width, tex_height, final_vertex,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_width, tex_height, final_vertex,
                  output ready);
endinterface

FILE: sv/stes_out_if.sv
// stes_out_if: result item channel (valid, ready, coordinates, triangle, extents)
// depends on stes_pkg
`timescale 1ns / 1ps

interface stes_out_if
  import stes_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] coord_s;
  logic signed [CoordW-1:0] coord_t;
  logic                     tri_valid;
  logic        [TriW-1:0]   tri_second;
  logic        [TriW-1:0]   tri_third;
  logic                     extents_valid;
  logic signed [OrgW-1:0]   origin_s;
  logic signed [OrgW-1:0]   origin_t;
  logic        [SpanW-1:0]  span_s;
  logic        [SpanW-1:0]  span_t;
  logic                     overflow;

  modport source (output valid, coord_s, coord_t, tri_valid, tri_second, tri_third,
                  extents_valid, origin_s, origin_t, span_s, span_t, overflow,
                  input ready);
  modport sink   (input valid, coord_s, coord_t, tri_valid, tri_second, tri_third,
                  extents_valid, origin_s, origin_t, span_s, span_t, overflow,
                  output ready);
endinterface

FILE: sv/stes_div.sv
// stes_div: bit-serial restoring divider, one quotient bit per cycle while step is held
// depends on stes_pkg
`timescale 1ns / 1ps

module stes_div
  import stes_pkg::*;
(
  input  logic             clk_i,
  input  div_ctrl_t        ctrl_i,
  input  logic [DvW-1:0]   dividend_i,
  input  logic [SizeW-1:0] divisor_i,
  output logic [DvW-1:0]   quot_o,
  output logic             rem_nz_o
);

  logic [DvW-1:0]   dv_q, dv_d;
  logic [SizeW-1:0] rem_q, rem_d;
  logic [SizeW-1:0] dsr_q;
  logic [SizeW:0]   trial;
  logic             ge;

  // dividend shifts out the top while quotient bits shift in at the bottom
  always_comb begin
    trial = {rem_q, dv_q[DvW-1]};
    ge    = trial >= {1'b0, dsr_q};
    rem_d = ge ? SizeW'(trial - {1'b0, dsr_q}) : trial[SizeW-1:0];
    dv_d  = {dv_q[DvW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      dv_q  <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (ctrl_i.step) begin
      dv_q  <= dv_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o   = dv_q;
  assign rem_nz_o = |rem_q;

endmodule

FILE: sv/surface_texture_extent_setup.sv
// surface_texture_extent_setup: per-vertex texture coordinates, fan triangles, extents
// one item at a time: a vertex is accepted only in idle and passes through 7 multiply-accumulate
// steps, projection, divider load and 42 divide steps before its result is loaded into the
// output register; the next vertex is accepted only after that load
// reset: registers take their default axes, polygon state clears, no item pending
// depends on stes_pkg, stes_in_if, stes_out_if, stes_div
`timescale 1ns / 1ps

module surface_texture_extent_setup
  import stes_pkg::*;
#(
  parameter int unsigned MAX_VERTS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [AxisW-1:0]       cfg_data_i,
  stes_in_if.sink                vtx_i,
  stes_out_if.source             res_o
);

  localparam int unsigned CntW = $clog2(MAX_VERTS + 1);

  // configuration registers
  logic signed [AxisW-1:0] s_ax_q, s_ay_q, s_az_q, s_sh_q;
  logic signed [AxisW-1:0] t_ax_q, t_ay_q, t_az_q, t_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_ax_q <= AxisW'(65536);
      s_ay_q <= '0;
      s_az_q <= '0;
      s_sh_q <= '0;
      t_ax_q <= '0;
      t_ay_q <= AxisW'(65536);
      t_az_q <= '0;
      t_sh_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_S_AXIS_X: s_ax_q <= cfg_data_i;
        REG_S_AXIS_Y: s_ay_q <= cfg_data_i;
        REG_S_AXIS_Z: s_az_q <= cfg_data_i;
        REG_S_SHIFT:  s_sh_q <= cfg_data_i;
        REG_T_AXIS_X: t_ax_q <= cfg_data_i;
        REG_T_AXIS_Y: t_ay_q <= cfg_data_i;
        REG_T_AXIS_Z: t_az_q <= cfg_data_i;
        REG_T_SHIFT:  t_sh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  state_e state_q, state_d;
  logic [2:0]        step_q, step_d;
  logic [DvCntW-1:0] dcnt_q, dcnt_d;
  logic              accept, load_out;

  assign accept   = vtx_i.valid && vtx_i.ready;
  assign load_out = (state_q == ST_DONE) && (!res_o.valid || res_o.ready);
  assign vtx_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dcnt_d  = dcnt_q;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (accept) state_d = ST_MUL;
      end
      ST_MUL: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd6) state_d = ST_PROJ;
      end
      ST_PROJ: state_d = ST_LOAD;
      ST_LOAD: begin
        dcnt_d  = DvCntW'(DvW);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        dcnt_d = dcnt_q - DvCntW'(1);
        if (dcnt_q == DvCntW'(1)) state_d = ST_DONE;
      end
      ST_DONE: if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      dcnt_q  <= dcnt_d;
    end
  end

  // latched vertex
  logic signed [PosW-1:0] px_q, py_q, pz_q;
  logic [SizeW-1:0]       tw_q, th_q;
  logic                   fin_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q  <= vtx_i.pos_x;
      py_q  <= vtx_i.pos_y;
      pz_q  <= vtx_i.pos_z;
      // a zero size divides as one
      tw_q  <= (vtx_i.tex_width  == '0) ? SizeW'(1) : vtx_i.tex_width;
      th_q  <= (vtx_i.tex_height == '0) ? SizeW'(1) : vtx_i.tex_height;
      fin_q <= vtx_i.final_vertex;
    end
  end

  // one shared multiplier: step k forms product k, step k+1 accumulates it
  logic signed [PosW-1:0]  mul_a;
  logic signed [AxisW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_s_q, acc_t_q;

  always_comb begin
    case (step_q)
      3'd0:    begin mul_a = px_q; mul_b = s_ax_q; end
      3'd1:    begin mul_a = py_q; mul_b = s_ay_q; end
      3'd2:    begin mul_a = pz_q; mul_b = s_az_q; end
      3'd3:    begin mul_a = px_q; mul_b = t_ax_q; end
      3'd4:    begin mul_a = py_q; mul_b = t_ay_q; end
      default: begin mul_a = pz_q; mul_b = t_az_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      acc_s_q <= '0;
      acc_t_q <= '0;
    end else if (state_q == ST_MUL) begin
      prod_q <= mul_a * mul_b;
      if (step_q >= 3'd1 && step_q <= 3'd3) acc_s_q <= acc_s_q + AccW'(prod_q);
      if (step_q >= 3'd4)                   acc_t_q <= acc_t_q + AccW'(prod_q);
    end
  end

  // projection: floor by 2^16 is the arithmetic shift, then the offset
  logic signed [ProjW-1:0] proj_s_q, proj_t_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PROJ) begin
      proj_s_q <= acc_s_q[AccW-1:16] + ProjW'(s_sh_q);
      proj_t_q <= acc_t_q[AccW-1:16] + ProjW'(t_sh_q);
    end
  end

  // divider setup: magnitude of projection times 256
  logic             neg_s_q, neg_t_q;
  logic [ProjW-1:0] mag_s, mag_t;
  div_ctrl_t        dctl;
  logic [DvW-1:0]   quot_s, quot_t;
  logic             rnz_s, rnz_t;

  assign mag_s      = proj_s_q[ProjW-1] ? ProjW'(-proj_s_q) : proj_s_q;
  assign mag_t      = proj_t_q[ProjW-1] ? ProjW'(-proj_t_q) : proj_t_q;
  assign dctl.start = (state_q == ST_LOAD);
  assign dctl.step  = (state_q == ST_DIV);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      neg_s_q <= proj_s_q[ProjW-1];
      neg_t_q <= proj_t_q[ProjW-1];
    end
  end

  stes_div u_div_s (
    .clk_i      (clk_i),
    .ctrl_i     (dctl),
    .dividend_i ({mag_s, 8'd0}),
    .divisor_i  (tw_q),
    .quot_o     (quot_s),
    .rem_nz_o   (rnz_s)
  );

  stes_div u_div_t (
    .clk_i      (clk_i),
    .ctrl_i     (dctl),
    .dividend_i ({mag_t, 8'd0}),
    .divisor_i  (th_q),
    .quot_o     (quot_t),
    .rem_nz_o   (rnz_t)
  );

  // polygon state: running extents, vertex count, saturation flag
  logic signed [ProjW-1:0] low_s_q, high_s_q, low_t_q, high_t_q;
  logic [CntW-1:0]         cnt_q;
  logic                    sat_q;
  logic                    room;

  localparam logic signed [ProjW-1:0] ExtPos = {1'b0, {(ProjW-1){1'b1}}};
  localparam logic signed [ProjW-1:0] ExtNeg = {1'b1, {(ProjW-1){1'b0}}};

  assign room = (cnt_q < CntW'(MAX_VERTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_s_q  <= ExtPos;
      high_s_q <= ExtNeg;
      low_t_q  <= ExtPos;
      high_t_q <= ExtNeg;
      cnt_q    <= '0;
      sat_q    <= 1'b0;
    end else if (state_q == ST_LOAD) begin
      if (proj_s_q < low_s_q)  low_s_q  <= proj_s_q;
      if (proj_s_q > high_s_q) high_s_q <= proj_s_q;
      if (proj_t_q < low_t_q)  low_t_q  <= proj_t_q;
      if (proj_t_q > high_t_q) high_t_q <= proj_t_q;
    end else if (load_out) begin
      if (fin_q) begin
        // polygon closes: back to the cleared state
        low_s_q  <= ExtPos;
        high_s_q <= ExtNeg;
        low_t_q  <= ExtPos;
        high_t_q <= ExtNeg;
        cnt_q    <= '0;
        sat_q    <= 1'b0;
      end else if (room) begin
        cnt_q <= cnt_q + CntW'(1);
      end else begin
        sat_q <= 1'b1;
      end
    end
  end

  // floor quotient from magnitude quotient, then clamp to Q17.16 range
  function automatic logic [CoordW-1:0] fix_coord(input logic [DvW-1:0] q,
                                                  input logic neg, input logic rnz);
    logic [DvW:0] r;
    r = {1'b0, q};
    if (neg) r = rnz ? ~r : (DvW+1)'(-r);
    if (r[DvW:CoordW-1] == '0 || r[DvW:CoordW-1] == '1) begin
      fix_coord = r[CoordW-1:0];
    end else if (r[DvW]) begin
      fix_coord = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      fix_coord = {1'b0, {(CoordW-1){1'b1}}};
    end
  endfunction

  // block alignment: floor and ceiling by 16 texels = 4096 in Q.8
  logic signed [ProjW-13:0] bs0, bt0, bs1, bt1;
  logic signed [ProjW:0]    hs_up, ht_up;
  logic signed [ProjW-13:0] ds, dt;
  logic [8:0]               n9;
  logic                     tri_v;

  assign bs0   = low_s_q[ProjW-1:12];
  assign bt0   = low_t_q[ProjW-1:12];
  assign hs_up = (ProjW+1)'(high_s_q) + (ProjW+1)'(4095);
  assign ht_up = (ProjW+1)'(high_t_q) + (ProjW+1)'(4095);
  assign bs1   = hs_up[ProjW-1:12];
  assign bt1   = ht_up[ProjW-1:12];
  assign ds    = bs1 - bs0;
  assign dt    = bt1 - bt0;
  assign n9    = 9'(cnt_q);
  assign tri_v = room && (n9 >= 9'd2);

  // output register
  logic                     ov_q;
  logic signed [CoordW-1:0] cs_q, ct_q;
  logic                     tv_q, ev_q, of_q;
  logic        [TriW-1:0]   t2_q, t3_q;
  logic signed [OrgW-1:0]   os_q, ot_q;
  logic        [SpanW-1:0]  ss_q, st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (load_out) begin
      ov_q <= 1'b1;
    end else if (res_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      cs_q <= fix_coord(quot_s, neg_s_q, rnz_s);
      ct_q <= fix_coord(quot_t, neg_t_q, rnz_t);
      tv_q <= tri_v;
      t2_q <= tri_v ? TriW'(n9 - 9'd1) : '0;
      t3_q <= tri_v ? n9[TriW-1:0] : '0;
      of_q <= sat_q || !room;
      ev_q <= fin_q;
      os_q <= fin_q ? {bs0[OrgW-5:0], 4'd0} : '0;
      ot_q <= fin_q ? {bt0[OrgW-5:0], 4'd0} : '0;
      ss_q <= fin_q ? {ds[SpanW-5:0], 4'd0} : '0;
      st_q <= fin_q ? {dt[SpanW-5:0], 4'd0} : '0;
    end
  end

  assign res_o.valid         = ov_q;
  assign res_o.coord_s       = cs_q;
  assign res_o.coord_t       = ct_q;
  assign res_o.tri_valid     = tv_q;
  assign res_o.tri_second    = t2_q;
  assign res_o.tri_third     = t3_q;
  assign res_o.extents_valid = ev_q;
  assign res_o.origin_s      = os_q;
  assign res_o.origin_t      = ot_q;
  assign res_o.span_s        = ss_q;
  assign res_o.span_t        = st_q;
  assign res_o.overflow      = of_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_VERTS))
    else $error("vertex count beyond limit");

  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> cnt_q == CntW'(MAX_VERTS))
    else $error("saturation flag without full count");

  a_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_MUL && step_q == 3'd0)
    else $error("accepted item did not start multiply");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> dcnt_q == '0)
    else $error("result formed before divide finished");

endmodule
